>>> rtl/core/smsu_pkg.sv
package smsu_pkg;

    localparam int DEF_NUM_STACKS = 4;
    localparam int DEF_DEPTH      = 16;

    localparam int SEL_W      = 2;
    localparam int VALUE_W    = 32;
    localparam int STATUS_W   = 2;
    localparam int S_TDATA_W  = 40;
    localparam int M_TDATA_W  = 32;

    localparam logic MODE_PUSH = 1'b0;
    localparam logic MODE_POP  = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EVAL,
        S_POP
    } state_t;

    typedef struct packed {
        logic capture;
        logic fetch;
        logic commit;
    } cmd_t;

    typedef struct packed {
        logic is_pop;
        logic pop_ok;
    } sts_t;

endpackage

>>> rtl/core/shared_array_multi_stack_unit.sv
// Shared-array multi-stack unit.
// NUM_STACKS LIFO stacks share one store of DEPTH slots; free slots form a linked list.
// Input channel (s_): s_tuser is the opcode (0 push, 1 pop); s_tdata carries the
// stack number and, for a push, the 32-bit value. Each input transaction yields
// exactly one output transaction on the m_ channel: m_tuser is the status
// (0 done, 1 store full, 2 stack empty), m_tdata the popped value or zero.
// Sequence: a push or a failed pop reaches the output register from S_EVAL, a successful pop
// from S_POP after S_EVAL, since the pop reads the link and data of the stack top only after
// the top itself has been read; either waits in its state until the output register is free.
// One item at a time: the next transaction is taken only after the read-then-write pass over
// the link, top and data memories for the last one is done and its result is committed.
// Reset: all stacks empty, free list 0..DEPTH-1 in order; there is no clearing pass,
// unwritten link entries are tracked by a fill count.
// Stall: the result waits in the output register; the next item is still taken,
// and its own result waits until the output register is free.
module shared_array_multi_stack_unit #(
    parameter int NUM_STACKS = smsu_pkg::DEF_NUM_STACKS,
    parameter int DEPTH      = smsu_pkg::DEF_DEPTH
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [smsu_pkg::S_TDATA_W-1:0]  s_tdata,  // [1:0] stack_sel, [33:2] value
    input  logic                            s_tuser,  // [0] mode
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [smsu_pkg::M_TDATA_W-1:0]  m_tdata,  // [31:0] popped
    output logic [smsu_pkg::STATUS_W-1:0]   m_tuser   // [1:0] status
);

    smsu_pkg::cmd_t cmd;
    smsu_pkg::sts_t sts;

    smsu_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    smsu_datapath #(
        .NUM_STACKS (NUM_STACKS),
        .DEPTH      (DEPTH)
    ) u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .cmd     (cmd),
        .sts     (sts)
    );

endmodule

>>> rtl/core/smsu_ctrl.sv
module smsu_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_tvalid,
    output logic            s_tready,
    output logic            m_tvalid,
    input  logic            m_tready,
    input  smsu_pkg::sts_t  sts,
    output smsu_pkg::cmd_t  cmd
);

    smsu_pkg::state_t state_reg, state_next;
    logic             m_tvalid_reg, m_tvalid_next;
    logic             out_free;

    assign out_free = !m_tvalid_reg || m_tready;
    assign m_tvalid = m_tvalid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= smsu_pkg::S_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_comb begin
        state_next  = state_reg;
        cmd         = '0;
        s_tready    = 1'b0;
        unique case (state_reg)
            smsu_pkg::S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.capture = 1'b1;
                    state_next  = smsu_pkg::S_EVAL;
                end
            end
            smsu_pkg::S_EVAL: begin
                if (sts.is_pop && sts.pop_ok) begin
                    cmd.fetch  = 1'b1;
                    state_next = smsu_pkg::S_POP;
                end else if (out_free) begin
                    cmd.commit = 1'b1;
                    state_next = smsu_pkg::S_IDLE;
                end
            end
            smsu_pkg::S_POP: begin
                if (out_free) begin
                    cmd.commit = 1'b1;
                    state_next = smsu_pkg::S_IDLE;
                end
            end
            default: state_next = smsu_pkg::S_IDLE;
        endcase
        if (cmd.commit) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end else begin
            m_tvalid_next = m_tvalid_reg;
        end
    end

endmodule

>>> rtl/core/smsu_datapath.sv
module smsu_datapath #(
    parameter int NUM_STACKS = smsu_pkg::DEF_NUM_STACKS,
    parameter int DEPTH      = smsu_pkg::DEF_DEPTH
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic [smsu_pkg::S_TDATA_W-1:0]  s_tdata,
    input  logic                            s_tuser,
    output logic [smsu_pkg::M_TDATA_W-1:0]  m_tdata,
    output logic [smsu_pkg::STATUS_W-1:0]   m_tuser,
    input  smsu_pkg::cmd_t                  cmd,
    output smsu_pkg::sts_t                  sts
);

    localparam int AW   = $clog2(DEPTH + 1);
    localparam int IW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int SW   = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;
    localparam int WW   = SW + smsu_pkg::SEL_W;
    localparam int VW   = smsu_pkg::VALUE_W;
    localparam logic [AW-1:0] NULL_SLOT = AW'(DEPTH);

    logic [VW-1:0] data_mem [DEPTH];
    logic [AW-1:0] link_mem [DEPTH];
    logic [AW-1:0] top_mem  [NUM_STACKS];

    logic [NUM_STACKS-1:0] top_valid_reg;
    logic                  mode_reg;
    logic [SW-1:0]         idx_reg;
    logic                  in_range_reg;
    logic [VW-1:0]         value_reg;
    logic [AW-1:0]         free_head_reg;
    logic [AW-1:0]         fill_reg;
    logic [AW-1:0]         top_q_reg;
    logic                  top_v_reg;
    logic [AW-1:0]         link_q_reg;
    logic [VW-1:0]         data_q_reg;
    logic [smsu_pkg::STATUS_W-1:0] status_reg;
    logic [VW-1:0]         popped_reg;

    logic [smsu_pkg::SEL_W-1:0] s_sel;
    logic [WW-1:0]              s_sel_wide;
    logic [SW-1:0]              s_idx;
    logic [AW-1:0]              top_cur;
    logic                       push_ok;
    logic                       pop_ok;
    logic                       fresh;
    logic [AW-1:0]              next_free;
    logic [IW-1:0]              link_raddr;

    assign s_sel      = s_tdata[smsu_pkg::SEL_W-1:0];
    assign s_sel_wide = WW'(s_sel);
    assign s_idx      = s_sel_wide[SW-1:0];

    assign top_cur    = top_v_reg ? top_q_reg : NULL_SLOT;
    assign push_ok    = in_range_reg && (free_head_reg < NULL_SLOT);
    assign pop_ok     = in_range_reg && (top_cur < NULL_SLOT);
    assign fresh      = (free_head_reg == fill_reg);
    assign next_free  = fresh ? (fill_reg + AW'(1)) : link_q_reg;
    assign link_raddr = cmd.capture ? free_head_reg[IW-1:0] : top_cur[IW-1:0];

    assign sts.is_pop = (mode_reg == smsu_pkg::MODE_POP);
    assign sts.pop_ok = pop_ok;

    assign m_tdata = popped_reg;
    assign m_tuser = status_reg;

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            mode_reg     <= s_tuser;
            idx_reg      <= s_idx;
            in_range_reg <= (s_sel_wide < WW'(NUM_STACKS));
            value_reg    <= s_tdata[smsu_pkg::SEL_W +: VW];
            top_q_reg    <= top_mem[s_idx];
            top_v_reg    <= top_valid_reg[s_idx];
        end
        if (cmd.capture || cmd.fetch) begin
            link_q_reg <= link_mem[link_raddr];
        end
        if (cmd.fetch) begin
            data_q_reg <= data_mem[top_cur[IW-1:0]];
        end
        if (cmd.commit) begin
            if (mode_reg == smsu_pkg::MODE_PUSH) begin
                if (push_ok) begin
                    data_mem[free_head_reg[IW-1:0]] <= value_reg;
                    link_mem[free_head_reg[IW-1:0]] <= top_cur;
                    top_mem[idx_reg]                <= free_head_reg;
                    status_reg                      <= smsu_pkg::ST_DONE;
                end else begin
                    status_reg <= smsu_pkg::ST_FULL;
                end
                popped_reg <= '0;
            end else if (pop_ok) begin
                top_mem[idx_reg]          <= link_q_reg;
                link_mem[top_cur[IW-1:0]] <= free_head_reg;
                status_reg                <= smsu_pkg::ST_DONE;
                popped_reg                <= data_q_reg;
            end else begin
                status_reg <= smsu_pkg::ST_EMPTY;
                popped_reg <= '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            top_valid_reg <= '0;
            free_head_reg <= '0;
            fill_reg      <= '0;
        end else if (cmd.commit) begin
            if (mode_reg == smsu_pkg::MODE_PUSH) begin
                if (push_ok) begin
                    top_valid_reg[idx_reg] <= 1'b1;
                    free_head_reg          <= next_free;
                    if (fresh) begin
                        fill_reg <= fill_reg + AW'(1);
                    end
                end
            end else if (pop_ok) begin
                free_head_reg <= top_cur;
            end
        end
    end

endmodule

>>> rtl/core/smsu_checker.sv
module smsu_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [smsu_pkg::M_TDATA_W-1:0]  m_tdata,
    input logic [smsu_pkg::STATUS_W-1:0]   m_tuser
);

    // held result must not change
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("output changed while stalled");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser == smsu_pkg::ST_DONE || m_tuser == smsu_pkg::ST_FULL ||
                      m_tuser == smsu_pkg::ST_EMPTY))
        else $error("bad status code");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser != smsu_pkg::ST_DONE |-> m_tdata == '0)
        else $error("nonzero data on failed transaction");

    // one item in flight
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken in back-to-back cycles");

endmodule

bind shared_array_multi_stack_unit smsu_checker u_smsu_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
